// File: src/ldm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linked deque manager.
// No dependencies; imported by linked_deque_manager_core.
package ldm_pkg;

    localparam int HANDLE_W = 8;
    localparam int ENTRIES  = 256;
    localparam int LINK_W   = HANDLE_W + 1;
    // Bit of a link word that marks the end of the list.
    localparam int LINK_END = HANDLE_W;

    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [LINK_W-1:0]   link_t;

    typedef enum logic [1:0] {
        KIND_PUSH_LEFT  = 2'd0,
        KIND_PUSH_RIGHT = 2'd1,
        KIND_POP_LEFT   = 2'd2,
        KIND_POP_RIGHT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_DUP   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

// File: src/linked_deque_manager_core.sv
`timescale 1ns / 1ps
// Double-ended queue of entry handles kept as a doubly linked list.
// Depends on ldm_pkg for types, codes and table sizes.

// Each beat pushes a handle at the left or right end of the queue or pops
// one end. The links live in two synchronous RAMs (next and previous);
// membership bits live in flip-flops that reset clears, so no clearing
// pass is needed. In the cycle a beat is accepted the block reads the one
// link it may need; in the execute state that follows it writes up to one
// entry of each link RAM, updates head and tail, and loads the result
// register. No new beat is taken until the previous one has executed; a
// waiting result stalls only the execute state of the following beat.
module linked_deque_manager_core
    import ldm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic [HANDLE_W-1:0] entry_handle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [HANDLE_W-1:0] popped_handle,
    output logic [1:0]          status
);

    state_t  state_reg, state_next;
    kind_t   kind_reg;
    handle_t handle_reg;
    handle_t head_reg, head_next;
    handle_t tail_reg, tail_next;
    logic    empty_reg, empty_next;
    logic [ENTRIES-1:0] in_queue_reg;

    logic    out_valid_reg, out_valid_next;
    handle_t popped_reg, popped_next;
    status_t status_reg, status_next;

    link_t next_mem [ENTRIES];
    link_t prev_mem [ENTRIES];
    link_t link_rd_reg;

    logic    in_fire, exec_go;
    logic    next_we, prev_we;
    handle_t next_wa, prev_wa;
    link_t   next_wd, prev_wd;
    logic    set_q, clr_q;
    handle_t q_idx;

    assign in_ready      = (state_reg == ST_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign exec_go       = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign out_valid     = out_valid_reg;
    assign popped_handle = popped_reg;
    assign status        = status_reg;

    // Link RAMs: the read is issued in the accept cycle only, so the read
    // data holds while the execute cycle stalls on the output.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (kind_t'(kind) == KIND_POP_LEFT)
                link_rd_reg <= next_mem[head_reg];
            else
                link_rd_reg <= prev_mem[tail_reg];
        end
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg   <= kind_t'(kind);
            handle_reg <= entry_handle;
        end
        if (exec_go)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        popped_next    = '0;
        status_next    = STATUS_OK;
        next_we        = 1'b0;
        prev_we        = 1'b0;
        next_wa        = handle_reg;
        prev_wa        = handle_reg;
        next_wd        = {1'b0, handle_reg};
        prev_wd        = {1'b0, handle_reg};
        set_q          = 1'b0;
        clr_q          = 1'b0;
        q_idx          = handle_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (kind_reg == KIND_PUSH_LEFT || kind_reg == KIND_PUSH_RIGHT)
                    begin
                        priority if (in_queue_reg[handle_reg])
                        begin
                            status_next = STATUS_DUP;
                        end
                        else if (empty_reg)
                        begin
                            set_q      = 1'b1;
                            head_next  = handle_reg;
                            tail_next  = handle_reg;
                            empty_next = 1'b0;
                        end
                        else if (kind_reg == KIND_PUSH_LEFT)
                        begin
                            // The end links of the new head are never read
                            // while it stays an end, so only the two inner
                            // links are written.
                            set_q     = 1'b1;
                            next_we   = 1'b1;
                            next_wa   = handle_reg;
                            next_wd   = {1'b0, head_reg};
                            prev_we   = 1'b1;
                            prev_wa   = head_reg;
                            prev_wd   = {1'b0, handle_reg};
                            head_next = handle_reg;
                        end
                        else
                        begin
                            set_q     = 1'b1;
                            prev_we   = 1'b1;
                            prev_wa   = handle_reg;
                            prev_wd   = {1'b0, tail_reg};
                            next_we   = 1'b1;
                            next_wa   = tail_reg;
                            next_wd   = {1'b0, handle_reg};
                            tail_next = handle_reg;
                        end
                    end
                    else if (empty_reg)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        clr_q = 1'b1;
                        if (kind_reg == KIND_POP_LEFT)
                            q_idx = head_reg;
                        else
                            q_idx = tail_reg;
                        popped_next = q_idx;
                        if (head_reg == tail_reg || link_rd_reg[LINK_END])
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else if (kind_reg == KIND_POP_LEFT)
                            head_next = link_rd_reg[HANDLE_W-1:0];
                        else
                            tail_next = link_rd_reg[HANDLE_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            in_queue_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
            if (set_q)
                in_queue_reg[q_idx] <= 1'b1;
            else if (clr_q)
                in_queue_reg[q_idx] <= 1'b0;
        end
    end

endmodule
